FILE: rtl/raop_pkg.sv
// raop_pkg: shared types and constants for the router advertisement option parser
// holds the input/result transaction structs, status codes, byte classes and nd constants
// no dependencies
package raop_pkg;

    // nd protocol constants
    localparam logic [7:0]  ICMP6_TYPE_RA          = 8'd134;
    localparam logic [7:0]  RA_REQ_HOP_LIMIT       = 8'd255;
    localparam logic [7:0]  OPT_TYPE_DNS           = 8'd25;
    localparam logic [7:0]  OPT_TYPE_SRC_LL        = 8'd1;
    localparam int unsigned ND_RA_FLAG_MANAGED_BIT = 7;
    localparam int unsigned ND_RA_FLAG_OTHER_BIT   = 6;
    localparam int unsigned ND_OPT_ALIGN_LOG2      = 3;
    localparam logic [10:0] MAC_ADDR_BYTES         = 11'd6;

    localparam int unsigned RA_HEADER_BYTES   = 16;
    localparam logic [10:0] RDNSS_HEAD_BYTES  = 11'd8;
    localparam logic [10:0] RDNSS_MIN_BYTES   = 11'd24;
    localparam int unsigned IPV6_ADDR_LOG2    = 4;
    localparam logic [10:0] LLADDR_HEAD_BYTES = 11'd2;

    // fixed header byte positions
    localparam int unsigned POS_TYPE    = 0;
    localparam int unsigned POS_CODE    = 1;
    localparam int unsigned POS_FLAGS   = 5;
    localparam int unsigned POS_LIFE_HI = 6;
    localparam int unsigned POS_LIFE_LO = 7;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_NOT_LL     = 3'd2;
    localparam logic [2:0] ST_BAD_TYPE   = 3'd3;
    localparam logic [2:0] ST_BAD_CODE   = 3'd4;
    localparam logic [2:0] ST_ZERO_LIFE  = 3'd5;
    localparam logic [2:0] ST_HOP_LIMIT  = 3'd6;
    localparam logic [2:0] ST_TOO_LONG   = 3'd7;

    typedef enum logic [2:0] {
        CLS_SKIP,
        CLS_TYPE,
        CLS_CODE,
        CLS_FLAGS,
        CLS_LIFE_HI,
        CLS_LIFE_LO,
        CLS_OPTION
    } t_byte_cls;

    typedef enum logic [1:0] {
        SRCH_SEARCHING,
        SRCH_FOUND,
        SRCH_STOPPED
    } t_search;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       packet_end;
        logic [7:0] hop_limit;
        logic       src_link_local;
    } t_rx_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        managed_flag;
        logic        other_flag;
        logic        options_truncated;
        logic [6:0]  dns_count;
        logic [10:0] dns_offset;
        logic        lladdr_found;
        logic [10:0] lladdr_offset;
        logic [10:0] lladdr_len;
    } t_ra_result;

    // what the front end attaches to each byte
    typedef struct packed {
        t_rx_item  item;
        t_byte_cls cls;
        logic      take;
    } t_fe_tag;

endpackage

FILE: rtl/router_advert_option_parser.sv
// result path: the byte marked packet_end passes through the byte queue, and the result
//   transaction is written to the output register when the back part pops that byte
// throughput: one byte per cycle while the queue has room; the byte queue lets the front
//   keep taking bytes while a finished result waits in the output register
// reset: synchronous active-low i_rst_n clears position, parse state, queue and output valid
//   at once; no clearing pass
module router_advert_option_parser
    import raop_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 2048,
    parameter int QUEUE_DEPTH      = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_rx_item   i_in_data,
    // result output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_ra_result o_out_data
);
    // position must reach one past the packet limit to flag overlong messages
    localparam int PW = $clog2(MAX_PACKET_BYTES + 2);
    localparam int QW = $bits(t_fe_tag) + PW;

    logic          fe_push;
    t_fe_tag       fe_tag;
    logic [PW-1:0] fe_pos;

    logic          q_ready;
    logic          q_valid;
    logic [QW-1:0] q_rdata;
    logic          be_pop;
    t_fe_tag       be_tag;
    logic [PW-1:0] be_pos;

    // input transaction is taken whenever the queue has room
    assign o_in_ready = q_ready;

    // front: byte position counter and per-byte classification
    raop_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
        .PW              (PW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_item   (i_in_data),
        .i_q_ready(q_ready),
        .o_push   (fe_push),
        .o_tag    (fe_tag),
        .o_pos    (fe_pos)
    );

    // short queue decoupling classification from the option walk
    raop_fifo #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (fe_push),
        .i_wdata({fe_tag, fe_pos}),
        .o_ready(q_ready),
        .i_pop  (be_pop),
        .o_rdata(q_rdata),
        .o_valid(q_valid)
    );

    assign be_tag = q_rdata[QW-1:PW];
    assign be_pos = q_rdata[PW-1:0];

    // back: header checks, option walk, result register
    // it only stalls on the final byte of a message while the result register is full and not being taken
    raop_back #(
        .PW(PW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_e_valid(q_valid),
        .i_e_tag  (be_tag),
        .i_e_pos  (be_pos),
        .o_pop    (be_pop),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_data   (o_out_data)
    );

endmodule

FILE: rtl/raop_fifo.sv
// raop_fifo: small first-word-fall-through queue between the front and back parts
// flop storage, power-of-two depth; no package dependency
module raop_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_ready,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_valid
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW:0]      r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_ready = (r_count != (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = push_ok ? AW'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = pop_ok  ? AW'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

FILE: rtl/raop_front.sv
// raop_front: accepts message bytes, counts position and classifies each byte
// depends on raop_pkg for the transaction and tag types
module raop_front
    import raop_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 2048,
    parameter int PW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_rx_item      i_item,
    input  logic          i_q_ready,
    output logic          o_push,
    output t_fe_tag       o_tag,
    output logic [PW-1:0] o_pos
);
    localparam logic [PW-1:0] POS_MAX  = PW'(MAX_PACKET_BYTES);
    localparam logic [PW-1:0] POS_OVER = PW'(MAX_PACKET_BYTES + 1);

    logic [PW-1:0] r_pos, n_pos;
    logic          take;
    t_byte_cls     cls;

    assign take   = (r_pos < POS_MAX);
    assign o_push = i_valid && i_q_ready;

    always_comb begin
        if (r_pos == PW'(POS_TYPE)) begin
            cls = CLS_TYPE;
        end else if (r_pos == PW'(POS_CODE)) begin
            cls = CLS_CODE;
        end else if (r_pos == PW'(POS_FLAGS)) begin
            cls = CLS_FLAGS;
        end else if (r_pos == PW'(POS_LIFE_HI)) begin
            cls = CLS_LIFE_HI;
        end else if (r_pos == PW'(POS_LIFE_LO)) begin
            cls = CLS_LIFE_LO;
        end else if (r_pos >= PW'(RA_HEADER_BYTES)) begin
            cls = CLS_OPTION;
        end else begin
            cls = CLS_SKIP;
        end
    end

    assign o_tag.item = i_item;
    assign o_tag.cls  = cls;
    assign o_tag.take = take;
    assign o_pos      = r_pos;

    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            if (i_item.packet_end) begin
                n_pos = '0;
            end else if (take) begin
                n_pos = r_pos + 1'b1;
            end else begin
                n_pos = POS_OVER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

FILE: rtl/raop_back.sv
// raop_back: runs the header checks and option walk on queued bytes, holds the result register
// depends on raop_pkg for types, status codes and nd constants
module raop_back
    import raop_pkg::*;
#(
    parameter int PW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_e_valid,
    input  t_fe_tag       i_e_tag,
    input  logic [PW-1:0] i_e_pos,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output t_ra_result    o_data
);
    localparam int CW = (PW > 11) ? PW : 11;
    localparam logic [PW-1:0] START_RESET = PW'(RA_HEADER_BYTES);
    localparam logic [PW-1:0] SHORT_LIMIT = PW'(RA_HEADER_BYTES - 1);

    logic [2:0]    r_hdr_err, n_hdr_err;
    logic [1:0]    r_flags, n_flags;
    logic [PW-1:0] r_opt_start, n_opt_start;
    logic [7:0]    r_opt_kind, n_opt_kind;
    logic [10:0]   r_opt_bytes, n_opt_bytes;
    logic          r_life, n_life;
    t_search       r_dns_st, n_dns_st;
    logic [6:0]    r_dns_cnt, n_dns_cnt;
    logic [10:0]   r_dns_off, n_dns_off;
    t_search       r_ll_st, n_ll_st;
    logic [10:0]   r_ll_off, n_ll_off;
    logic [10:0]   r_ll_len, n_ll_len;
    logic          r_trunc, n_trunc;
    logic          r_out_valid, n_out_valid;
    t_ra_result    r_out, n_out;

    logic [7:0]    b;
    logic          open_err;
    logic          life_v;
    logic          trunc_end;
    logic          ok;
    logic [2:0]    status;
    logic [CW-1:0] pos_cw, start_cw, rel;
    logic [10:0]   rd_span;

    assign o_pop   = i_e_valid && (!i_e_tag.item.packet_end || !r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign b        = i_e_tag.item.rx_byte;
    assign open_err = (r_hdr_err == ST_OK) || (r_hdr_err == ST_HOP_LIMIT);
    assign pos_cw   = CW'(i_e_pos);
    assign start_cw = CW'(r_opt_start);
    assign rel      = pos_cw - start_cw;
    assign rd_span  = r_opt_bytes - RDNSS_HEAD_BYTES;

    always_comb begin
        n_hdr_err   = r_hdr_err;
        n_flags     = r_flags;
        n_opt_start = r_opt_start;
        n_opt_kind  = r_opt_kind;
        n_opt_bytes = r_opt_bytes;
        n_life      = r_life;
        n_dns_st    = r_dns_st;
        n_dns_cnt   = r_dns_cnt;
        n_dns_off   = r_dns_off;
        n_ll_st     = r_ll_st;
        n_ll_off    = r_ll_off;
        n_ll_len    = r_ll_len;
        n_trunc     = r_trunc;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        life_v      = r_life;
        status      = ST_OK;
        trunc_end   = 1'b0;
        ok          = 1'b0;

        if (o_pop && i_e_tag.take) begin
            unique case (i_e_tag.cls)
                CLS_TYPE: begin
                    priority if (!i_e_tag.item.src_link_local) begin
                        n_hdr_err = ST_NOT_LL;
                    end else if (b != ICMP6_TYPE_RA) begin
                        n_hdr_err = ST_BAD_TYPE;
                    end else if (i_e_tag.item.hop_limit != RA_REQ_HOP_LIMIT) begin
                        n_hdr_err = ST_HOP_LIMIT;
                    end else begin
                        n_hdr_err = r_hdr_err;
                    end
                end
                CLS_CODE: begin
                    if (open_err && b != 8'd0) begin
                        n_hdr_err = ST_BAD_CODE;
                    end
                end
                CLS_FLAGS: begin
                    n_flags = {b[ND_RA_FLAG_MANAGED_BIT], b[ND_RA_FLAG_OTHER_BIT]};
                end
                CLS_LIFE_HI: begin
                    n_life = (b != 8'd0);
                end
                CLS_LIFE_LO: begin
                    if (open_err && !r_life && b == 8'd0) begin
                        n_hdr_err = ST_ZERO_LIFE;
                    end
                    n_life = 1'b0;
                end
                CLS_OPTION: begin
                    if (!r_trunc && pos_cw >= start_cw) begin
                        if (rel == CW'(0)) begin
                            n_opt_kind  = b;
                            n_opt_bytes = '0;
                            n_life      = 1'b0;
                        end else if (rel == CW'(1)) begin
                            n_opt_bytes = {b, ND_OPT_ALIGN_LOG2'(0)};
                            if (b == 8'd0) begin
                                n_trunc = 1'b1;
                            end
                        end else begin
                            if (rel >= CW'(4) && rel <= CW'(7) && b != 8'd0) begin
                                life_v = 1'b1;
                            end
                            n_life = life_v;
                            // last byte of this option: record finds, step to next
                            if (r_opt_bytes != '0 && rel == CW'(r_opt_bytes) - CW'(1)) begin
                                if (r_opt_kind == OPT_TYPE_DNS && r_dns_st == SRCH_SEARCHING) begin
                                    if (r_opt_bytes < RDNSS_MIN_BYTES) begin
                                        n_dns_st = SRCH_STOPPED;
                                    end else if (life_v) begin
                                        n_dns_st  = SRCH_FOUND;
                                        n_dns_cnt = 7'(rd_span >> IPV6_ADDR_LOG2);
                                        n_dns_off = 11'(start_cw + CW'(RDNSS_HEAD_BYTES));
                                    end
                                end
                                if (r_opt_kind == OPT_TYPE_SRC_LL
                                    && r_ll_st == SRCH_SEARCHING) begin
                                    if (r_opt_bytes < LLADDR_HEAD_BYTES + MAC_ADDR_BYTES) begin
                                        n_ll_st = SRCH_STOPPED;
                                    end else begin
                                        n_ll_st  = SRCH_FOUND;
                                        n_ll_off = 11'(start_cw + CW'(LLADDR_HEAD_BYTES));
                                        n_ll_len = r_opt_bytes - LLADDR_HEAD_BYTES;
                                    end
                                end
                                n_opt_start = PW'(start_cw + CW'(r_opt_bytes));
                            end
                        end
                    end
                end
                CLS_SKIP: begin
                end
                default: begin
                end
            endcase
        end

        if (o_pop && i_e_tag.item.packet_end) begin
            priority if (!i_e_tag.take) begin
                status = ST_TOO_LONG;
            end else if (i_e_pos < SHORT_LIMIT) begin
                status = ST_SHORT;
            end else begin
                status = n_hdr_err;
            end
            ok        = (status == ST_OK);
            trunc_end = n_trunc || (pos_cw > CW'(n_opt_start));

            n_out.status            = status;
            n_out.managed_flag      = ok && n_flags[1];
            n_out.other_flag        = ok && n_flags[0];
            n_out.options_truncated = ok && trunc_end;
            if (ok && !trunc_end && n_dns_st == SRCH_FOUND) begin
                n_out.dns_count  = n_dns_cnt;
                n_out.dns_offset = n_dns_off;
            end else begin
                n_out.dns_count  = '0;
                n_out.dns_offset = '0;
            end
            if (ok && !trunc_end && n_ll_st == SRCH_FOUND) begin
                n_out.lladdr_found  = 1'b1;
                n_out.lladdr_offset = n_ll_off;
                n_out.lladdr_len    = n_ll_len;
            end else begin
                n_out.lladdr_found  = 1'b0;
                n_out.lladdr_offset = '0;
                n_out.lladdr_len    = '0;
            end
            n_out_valid = 1'b1;

            // message done, back to clean state
            n_hdr_err   = ST_OK;
            n_flags     = '0;
            n_opt_start = START_RESET;
            n_opt_kind  = '0;
            n_opt_bytes = '0;
            n_life      = 1'b0;
            n_dns_st    = SRCH_SEARCHING;
            n_dns_cnt   = '0;
            n_dns_off   = '0;
            n_ll_st     = SRCH_SEARCHING;
            n_ll_off    = '0;
            n_ll_len    = '0;
            n_trunc     = 1'b0;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_err   <= ST_OK;
            r_flags     <= '0;
            r_opt_start <= START_RESET;
            r_opt_kind  <= '0;
            r_opt_bytes <= '0;
            r_life      <= 1'b0;
            r_dns_st    <= SRCH_SEARCHING;
            r_dns_cnt   <= '0;
            r_dns_off   <= '0;
            r_ll_st     <= SRCH_SEARCHING;
            r_ll_off    <= '0;
            r_ll_len    <= '0;
            r_trunc     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_hdr_err   <= n_hdr_err;
            r_flags     <= n_flags;
            r_opt_start <= n_opt_start;
            r_opt_kind  <= n_opt_kind;
            r_opt_bytes <= n_opt_bytes;
            r_life      <= n_life;
            r_dns_st    <= n_dns_st;
            r_dns_cnt   <= n_dns_cnt;
            r_dns_off   <= n_dns_off;
            r_ll_st     <= n_ll_st;
            r_ll_off    <= n_ll_off;
            r_ll_len    <= n_ll_len;
            r_trunc     <= n_trunc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

FILE: rtl/raop_checker.sv
// raop_checker: port-level checks on the result channel of the parser
// depends on raop_pkg; bound to router_advert_option_parser below
module raop_checker
    import raop_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_ra_result o_out_data
);

    // stalled result transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // failed status leaves both flags, truncation, dns fields and the link-layer find clear
    a_fail_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |->
            !o_out_data.managed_flag && !o_out_data.other_flag
            && !o_out_data.options_truncated && o_out_data.dns_count == '0
            && o_out_data.dns_offset == '0 && !o_out_data.lladdr_found)
        else $error("fields set on failed status");

    // truncated option list drops both finds
    a_trunc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.options_truncated |->
            o_out_data.dns_count == '0 && o_out_data.dns_offset == '0
            && !o_out_data.lladdr_found)
        else $error("find reported on truncated list");

    // no link-layer find means no offset or length
    a_ll_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.lladdr_found |->
            o_out_data.lladdr_offset == '0 && o_out_data.lladdr_len == '0)
        else $error("link-layer fields without find");

endmodule

bind router_advert_option_parser raop_checker u_raop_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
